FILE: rtl/dmri_pkg.sv
// Shared types and constants for the dual motor ramp and reverse interlock.
`timescale 1ns / 1ps

package dmri_pkg;

  // Level scale: quarter units of an 8-bit level, full scale 255 * 4.
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned GOAL_W    = 8;
  localparam int unsigned DUTY_W    = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [LEVEL_W-1:0] FULL_Q = LEVEL_W'(1020);

  // duty = round(q * 1023 / 1020) = q + floor((3q + 510) / 1020), q <= 1020.
  // The correction term steps up at these levels.
  localparam logic [LEVEL_W-1:0] DUTY_STEP1 = LEVEL_W'(170);
  localparam logic [LEVEL_W-1:0] DUTY_STEP2 = LEVEL_W'(510);
  localparam logic [LEVEL_W-1:0] DUTY_STEP3 = LEVEL_W'(850);

  localparam logic [CFG_W-1:0] RAMP_STEP_RST = CFG_W'(5);
  localparam logic [CFG_W-1:0] ZERO_BAND_RST = CFG_W'(4);

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_SET_A    = 3'd1,
    ACT_SET_B    = 3'd2,
    ACT_SET_BOTH = 3'd3,
    ACT_STOP     = 3'd4,
    ACT_REV_OFF  = 3'd5,
    ACT_REV_ONE  = 3'd6,
    ACT_REV_TWO  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_ONE  = 2'd1,
    DIR_TWO  = 2'd2
  } dir_e;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_RAMP_STEP = 1'b0,
    REG_ZERO_BAND = 1'b1
  } reg_idx_e;

endpackage

FILE: rtl/dmri_in_if.sv
// Command/tick input channel.
`timescale 1ns / 1ps

interface dmri_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       action;
  logic [dmri_pkg::GOAL_W-1:0]      level;

  modport source (output valid, action, level, input ready);
  modport sink   (input valid, action, level, output ready);
endinterface

FILE: rtl/dmri_out_if.sv
// Duty and reverse drive result channel.
`timescale 1ns / 1ps

interface dmri_out_if;
  logic                             valid;
  logic                             ready;
  logic [dmri_pkg::DUTY_W-1:0]      duty_a;
  logic [dmri_pkg::DUTY_W-1:0]      duty_b;
  logic                             reverse_one;
  logic                             reverse_two;

  modport source (output valid, duty_a, duty_b, reverse_one, reverse_two, input ready);
  modport sink   (input valid, duty_a, duty_b, reverse_one, reverse_two, output ready);
endinterface

FILE: rtl/dual_motor_ramp_reverse_interlock_top.sv
// Top level: dual channel duty ramp with reverse direction interlock.
//
//   channel   dir   handshake        payload
//   cmd_i     in    valid/ready      action[2:0], level[7:0]
//   res_o     out   valid/ready      duty_a[9:0], duty_b[9:0], reverse_one, reverse_two
//   apb       in    psel/penable     paddr[2:0], pwdata[31:0] -> prdata, pready (always 1)
//
// One beat per cycle sustained while res_o is ready.
// Stage 1 is an input register; stage 2 updates the ramp state and loads the
// result register, so the state loop closes within stage 2.
// A stalled result holds stage 2; stage 1 still takes one more beat.
// Async active-low reset: levels, targets and directions to zero, registers
// to ramp_step 5, zero_band 4.
`timescale 1ns / 1ps

module dual_motor_ramp_reverse_interlock_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dmri_in_if.sink                       cmd_i,
  dmri_out_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmri_pkg::APB_AW-1:0]   paddr,
  input  logic [dmri_pkg::APB_DW-1:0]   pwdata,
  output logic [dmri_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [dmri_pkg::CFG_W-1:0] ramp_step_q, zero_band_q;
  logic                       cfg_wr;
  dmri_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dmri_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q <= dmri_pkg::RAMP_STEP_RST;
      zero_band_q <= dmri_pkg::ZERO_BAND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dmri_pkg::REG_RAMP_STEP: ramp_step_q <= pwdata[dmri_pkg::CFG_W-1:0];
        dmri_pkg::REG_ZERO_BAND: zero_band_q <= pwdata[dmri_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dmri_pkg::REG_RAMP_STEP:
        prdata = {{(dmri_pkg::APB_DW-dmri_pkg::CFG_W){1'b0}}, ramp_step_q};
      dmri_pkg::REG_ZERO_BAND:
        prdata = {{(dmri_pkg::APB_DW-dmri_pkg::CFG_W){1'b0}}, zero_band_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 2 advances when the result register is free or draining
  // ---------------------------------------------------------------------------
  logic s1_vld_q, out_vld_q;
  logic out_en, s2_fire, cmd_take;

  assign out_en      = !out_vld_q || res_o.ready;
  assign s2_fire     = s1_vld_q && out_en;
  assign cmd_i.ready = !s1_vld_q || out_en;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  // Stage 1: input register
  dmri_pkg::action_e           act_q;
  logic [dmri_pkg::GOAL_W-1:0] lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      act_q <= dmri_pkg::action_e'(cmd_i.action);
      lvl_q <= cmd_i.level;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ramp state update
  // ---------------------------------------------------------------------------
  logic [dmri_pkg::LEVEL_W-1:0] level_a_q, level_b_q, level_a_d, level_b_d;
  logic [dmri_pkg::GOAL_W-1:0]  goal_a_q, goal_b_q, goal_a_d, goal_b_d;
  dmri_pkg::dir_e               wanted_q, applied_q, wanted_d, applied_d;

  // One ramp step toward the target; snaps when within ramp_step.
  function automatic logic [dmri_pkg::LEVEL_W-1:0] ramp_toward(
    input logic [dmri_pkg::LEVEL_W-1:0] cur,
    input logic [dmri_pkg::LEVEL_W-1:0] tgt,
    input logic [dmri_pkg::CFG_W-1:0]   step
  );
    logic                         up;
    logic [dmri_pkg::LEVEL_W-1:0] diff;
    up   = tgt > cur;
    diff = up ? (tgt - cur) : (cur - tgt);
    if (diff <= step) begin
      return tgt;
    end
    return up ? (cur + step) : (cur - step);
  endfunction

  // round(q * 1023 / 1020), halves up, clamped to full scale.
  function automatic logic [dmri_pkg::DUTY_W-1:0] to_duty(
    input logic [dmri_pkg::LEVEL_W-1:0] q
  );
    logic [dmri_pkg::LEVEL_W-1:0] v;
    v = (q > dmri_pkg::FULL_Q) ? dmri_pkg::FULL_Q : q;
    return dmri_pkg::DUTY_W'(v)
         + dmri_pkg::DUTY_W'(v >= dmri_pkg::DUTY_STEP1)
         + dmri_pkg::DUTY_W'(v >= dmri_pkg::DUTY_STEP2)
         + dmri_pkg::DUTY_W'(v >= dmri_pkg::DUTY_STEP3);
  endfunction

  logic [dmri_pkg::LEVEL_W-1:0] tgt_a, tgt_b;
  logic                         stopped;

  assign tgt_a   = {goal_a_q, 2'b00};
  assign tgt_b   = {goal_b_q, 2'b00};
  // Interlock judged on the levels after this tick's step
  assign stopped = (level_a_d <= zero_band_q) && (level_b_d <= zero_band_q)
                && (tgt_a <= zero_band_q) && (tgt_b <= zero_band_q);

  always_comb begin
    level_a_d = level_a_q;
    level_b_d = level_b_q;
    goal_a_d  = goal_a_q;
    goal_b_d  = goal_b_q;
    wanted_d  = wanted_q;
    applied_d = applied_q;
    unique case (act_q)
      dmri_pkg::ACT_TICK: begin
        level_a_d = ramp_toward(level_a_q, tgt_a, ramp_step_q);
        level_b_d = ramp_toward(level_b_q, tgt_b, ramp_step_q);
        if (wanted_q != applied_q && stopped) begin
          applied_d = wanted_q;
        end
      end
      dmri_pkg::ACT_SET_A:    goal_a_d = lvl_q;
      dmri_pkg::ACT_SET_B:    goal_b_d = lvl_q;
      dmri_pkg::ACT_SET_BOTH: begin
        goal_a_d = lvl_q;
        goal_b_d = lvl_q;
      end
      dmri_pkg::ACT_STOP: begin
        goal_a_d = '0;
        goal_b_d = '0;
      end
      // No interlock on switching reverse off
      dmri_pkg::ACT_REV_OFF: begin
        wanted_d  = dmri_pkg::DIR_NONE;
        applied_d = dmri_pkg::DIR_NONE;
      end
      dmri_pkg::ACT_REV_ONE: begin
        wanted_d = dmri_pkg::DIR_ONE;
        goal_a_d = '0;
        goal_b_d = '0;
      end
      dmri_pkg::ACT_REV_TWO: begin
        wanted_d = dmri_pkg::DIR_TWO;
        goal_a_d = '0;
        goal_b_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_a_q <= '0;
      level_b_q <= '0;
      goal_a_q  <= '0;
      goal_b_q  <= '0;
      wanted_q  <= dmri_pkg::DIR_NONE;
      applied_q <= dmri_pkg::DIR_NONE;
    end else if (s2_fire) begin
      level_a_q <= level_a_d;
      level_b_q <= level_b_d;
      goal_a_q  <= goal_a_d;
      goal_b_q  <= goal_b_d;
      wanted_q  <= wanted_d;
      applied_q <= applied_d;
    end
  end

  // Result register
  logic [dmri_pkg::DUTY_W-1:0] duty_a_q, duty_b_q;
  logic                        rev_one_q, rev_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      duty_a_q  <= to_duty(level_a_d);
      duty_b_q  <= to_duty(level_b_d);
      rev_one_q <= (applied_d == dmri_pkg::DIR_ONE);
      rev_two_q <= (applied_d == dmri_pkg::DIR_TWO);
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.duty_a      = duty_a_q;
  assign res_o.duty_b      = duty_b_q;
  assign res_o.reverse_one = rev_one_q;
  assign res_o.reverse_two = rev_two_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Both reverse drives never on together
  a_rev_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.reverse_one && res_o.reverse_two))
    else $error("both reverse drives active");

  // Applied direction changes only on a stage-2 tick or reverse off
  a_dir_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (applied_q != $past(applied_q)) |->
      ($past(s2_fire) && ($past(act_q) == dmri_pkg::ACT_TICK ||
                          $past(act_q) == dmri_pkg::ACT_REV_OFF)))
    else $error("applied direction changed outside tick or reverse off");

  // A newly engaged reverse direction needs both channels at rest
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (applied_q != $past(applied_q) && applied_q != dmri_pkg::DIR_NONE) |->
      (level_a_q <= zero_band_q && level_b_q <= zero_band_q))
    else $error("reverse engaged while a channel is running");

  // Levels stay within full scale
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_a_q <= dmri_pkg::FULL_Q && level_b_q <= dmri_pkg::FULL_Q)
    else $error("level beyond full scale");

endmodule
